// ----- src/svps_pkg.sv -----
package svps_pkg;

	localparam int MAX_STAGES_DEF   = 16;
	localparam int VOLTAGE_BITS_DEF = 16;

	localparam int KIND_W   = 2;
	localparam int DUR_W    = 16;
	localparam int IDX_W    = 16;
	localparam int STATUS_W = 4;
	localparam int TIME_W   = 20;
	localparam int COUNT_W  = 17;

	localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic [KIND_W-1:0] KIND_CONST   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STEPPED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EMIT    = 2'd2;
	// The fourth code of the kind field has no meaning; the block drops such items.
	localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK        = 4'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_DUR   = 4'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO_STEP = 4'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_SIGN  = 4'd3;
	localparam logic [STATUS_W-1:0] ST_SECOND    = 4'd4;
	localparam logic [STATUS_W-1:0] ST_FULL      = 4'd5;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 4'd6;
	localparam logic [STATUS_W-1:0] ST_BAD_SWEEP = 4'd7;
	localparam logic [STATUS_W-1:0] ST_SATURATED = 4'd8;

endpackage

// ----- src/svps_in_if.sv -----
interface svps_in_if import svps_pkg::*; #(
	parameter int VOLTAGE_BITS = VOLTAGE_BITS_DEF
) ();
	logic                           valid;
	logic                           ready;
	logic [KIND_W-1:0]              kind;
	logic signed [VOLTAGE_BITS-1:0] start_level;
	logic signed [VOLTAGE_BITS-1:0] stop_level;
	logic signed [VOLTAGE_BITS-1:0] step_level;
	logic [DUR_W-1:0]               duration;
	logic [IDX_W-1:0]               sweep_index;

	modport source (output valid, kind, start_level, stop_level, step_level,
		duration, sweep_index, input ready);
	modport sink (input valid, kind, start_level, stop_level, step_level,
		duration, sweep_index, output ready);
endinterface

// ----- src/svps_out_if.sv -----
interface svps_out_if import svps_pkg::*; #(
	parameter int VOLTAGE_BITS = VOLTAGE_BITS_DEF
) ();
	logic                           valid;
	logic                           ready;
	logic [STATUS_W-1:0]            status;
	logic [TIME_W-1:0]              pair_time;
	logic signed [VOLTAGE_BITS-1:0] pair_voltage;
	logic [COUNT_W-1:0]             sweep_total;
	logic                           last;

	modport source (output valid, status, pair_time, pair_voltage, sweep_total, last,
		input ready);
	modport sink (input valid, status, pair_time, pair_voltage, sweep_total, last,
		output ready);
endinterface

// ----- src/svps_ram.sv -----
module svps_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- src/stepped_voltage_protocol_sequencer.sv -----
// Stepped voltage protocol sequencer.
// Items arrive on cmd and results leave on res, both valid/ready channels.
// A constant or stepped add item gives one status result. A constant add, a
// rejected add and every emit error go into the result register when accepted.
// An accepted stepped add runs the sweep count divider, one quotient bit per cycle,
// and loads its result once the divider is done and the result register is free.
// An emit item walks the stage memory, one read per cycle unless res stalls,
// and gives stage_count + 1 pairs; each read passes the s1 and s2 registers before
// the result register, and one pair follows each cycle unless res stalls.
// The block takes one item at a time: cmd.ready is high only when no item is in
// work and the result register is free or being read.
// When res stalls, the whole read pipeline freezes with the stage memory read port,
// and nothing is lost. Reset empties the table, clears the stepped flag and sets the
// sweep count to one; the stage memory itself is not cleared, since only entries
// below the stage count are ever used.
module stepped_voltage_protocol_sequencer import svps_pkg::*; #(
	parameter int MAX_STAGES   = MAX_STAGES_DEF,
	parameter int VOLTAGE_BITS = VOLTAGE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	svps_in_if.sink    cmd,
	svps_out_if.source res
);
	localparam int VB  = VOLTAGE_BITS;
	localparam int AW  = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
	localparam int CW  = $clog2(MAX_STAGES + 1);
	localparam int RW  = 2 * VB + DUR_W;
	localparam int PW  = VB + IDX_W + 1;
	localparam int SW  = PW + 1;
	localparam int DCW = $clog2(VB + 1);
	localparam int NW  = (VB + 1 > COUNT_W) ? VB + 1 : COUNT_W;

	localparam logic signed [SW-1:0] VMAX = SW'((64'd1 << (VB - 1)) - 64'd1);
	localparam logic signed [SW-1:0] VMIN = -VMAX - SW'(1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EMIT = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]         state_q;
	logic [CW-1:0]      count_q;
	logic               stepped_q;
	logic [COUNT_W-1:0] sweep_q;

	logic               walk_q;
	logic [CW-1:0]      ptr_q;
	logic [TIME_W-1:0]  acc_q;
	logic [IDX_W-1:0]   idx_q;

	logic               valid_s1, close_s1, last_s1;
	logic               valid_s2, last_s2;
	logic [TIME_W-1:0]  time_s2;
	logic signed [VB-1:0] start_s2;
	logic signed [PW-1:0] prod_s2;

	logic [VB-1:0]      rem_q, quo_q, div_q;
	logic [DCW-1:0]     dcnt_q;

	logic                 out_valid_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [TIME_W-1:0]    out_time_q;
	logic signed [VB-1:0] out_volt_q;
	logic [COUNT_W-1:0]   out_total_q;
	logic                 out_last_q;

	logic advance, accept;
	assign advance = !out_valid_q || res.ready;
	assign cmd.ready = arst_n && (state_q == S_IDLE) && advance;
	assign accept = cmd.valid && cmd.ready;

	// Add checks.
	logic               full;
	logic [STATUS_W-1:0] const_status, step_status;
	logic signed [VB:0] diff;
	logic [VB:0]        diff_abs;
	logic [VB:0]        step_abs;
	always_comb begin
		full = (count_q >= CW'(MAX_STAGES));
		diff = $signed({cmd.stop_level[VB-1], cmd.stop_level})
			- $signed({cmd.start_level[VB-1], cmd.start_level});
		diff_abs = diff[VB] ? (VB+1)'(-diff) : diff;
		step_abs = cmd.step_level[VB-1]
			? (VB+1)'(-$signed({cmd.step_level[VB-1], cmd.step_level}))
			: {1'b0, cmd.step_level};
		if (cmd.duration == '0) begin
			const_status = ST_BAD_DUR;
		end else if (full) begin
			const_status = ST_FULL;
		end else begin
			const_status = ST_OK;
		end
		if (stepped_q) begin
			step_status = ST_SECOND;
		end else if (cmd.duration == '0) begin
			step_status = ST_BAD_DUR;
		end else if (cmd.step_level == '0) begin
			step_status = ST_ZERO_STEP;
		end else if ((cmd.stop_level < cmd.start_level && !cmd.step_level[VB-1])
			|| (cmd.stop_level > cmd.start_level && cmd.step_level[VB-1])) begin
			step_status = ST_BAD_SIGN;
		end else if (full) begin
			step_status = ST_FULL;
		end else begin
			step_status = ST_OK;
		end
	end

	logic step_ok;
	assign step_ok = (cmd.kind == KIND_STEPPED) && (step_status == ST_OK);

	// Stage memory.
	logic            ram_we;
	logic [RW-1:0]   ram_wdata, ram_rdata;
	logic [AW-1:0]   ram_raddr;
	logic            is_close;
	always_comb begin
		ram_we = accept && ((cmd.kind == KIND_CONST && const_status == ST_OK)
			|| (cmd.kind == KIND_STEPPED && step_status == ST_OK));
		ram_wdata = {cmd.start_level,
			(cmd.kind == KIND_STEPPED) ? cmd.step_level : {VB{1'b0}}, cmd.duration};
		is_close = (ptr_q == count_q);
		ram_raddr = is_close ? AW'(count_q - CW'(1)) : AW'(ptr_q);
	end

	svps_ram #(.WIDTH(RW), .DEPTH(MAX_STAGES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(count_q)),
		.wdata (ram_wdata),
		.re    (advance),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	logic signed [VB-1:0] rd_start, rd_inc;
	logic [DUR_W-1:0]     rd_len;
	logic [TIME_W:0]      acc_sum;
	assign rd_start = ram_rdata[RW-1 -: VB];
	assign rd_inc   = ram_rdata[DUR_W +: VB];
	assign rd_len   = ram_rdata[DUR_W-1:0];
	assign acc_sum  = {1'b0, acc_q} + (TIME_W+1)'(rd_len);

	// Voltage add and saturation at the output.
	logic signed [SW-1:0]  vsum;
	logic signed [VB-1:0]  vsat;
	logic [STATUS_W-1:0]   vstatus;
	always_comb begin
		vsum = $signed({{(SW-VB){start_s2[VB-1]}}, start_s2})
			+ $signed({prod_s2[PW-1], prod_s2});
		if (vsum > VMAX) begin
			vsat = VMAX[VB-1:0];
			vstatus = ST_SATURATED;
		end else if (vsum < VMIN) begin
			vsat = VMIN[VB-1:0];
			vstatus = ST_SATURATED;
		end else begin
			vsat = vsum[VB-1:0];
			vstatus = ST_OK;
		end
	end

	// Divider step and sweep count.
	logic [VB:0]        trial;
	logic               fits;
	logic [NW-1:0]      n_ext;
	logic [COUNT_W-1:0] n_sat;
	always_comb begin
		trial = {rem_q, quo_q[VB-1]};
		fits = (trial >= {1'b0, div_q});
		n_ext = NW'(quo_q) + NW'(1);
		n_sat = (n_ext > NW'(COUNT_MAX)) ? COUNT_MAX : n_ext[COUNT_W-1:0];
	end

	logic emit_start;
	assign emit_start = accept && cmd.kind == KIND_EMIT && count_q != '0
		&& COUNT_W'(cmd.sweep_index) < sweep_q;

	// The result register takes a new item in the same cycle as it hands one over.
	logic out_load;
	always_comb begin
		case (state_q)
			S_IDLE: begin
				out_load = accept && !emit_start && !step_ok && cmd.kind != KIND_UNUSED;
			end
			S_EMIT: begin
				out_load = advance && valid_s2;
			end
			S_FIN: begin
				out_load = advance;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			stepped_q   <= 1'b0;
			sweep_q     <= COUNT_W'(1);
			walk_q      <= 1'b0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			dcnt_q      <= '0;
		end else begin
			if (ram_we) begin
				count_q <= count_q + CW'(1);
			end
			if (advance) begin
				valid_s1 <= walk_q;
				valid_s2 <= valid_s1;
			end
			if (advance && walk_q && is_close) begin
				walk_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (emit_start) begin
							walk_q  <= 1'b1;
							state_q <= S_EMIT;
						end else if (step_ok) begin
							stepped_q <= 1'b1;
							dcnt_q    <= '0;
							state_q   <= S_DIV;
						end
					end
				end
				S_EMIT: begin
					if (advance && valid_s2 && last_s2) begin
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					dcnt_q <= dcnt_q + DCW'(1);
					if (dcnt_q == DCW'(VB - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (advance) begin
						sweep_q <= n_sat;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit_start) begin
			ptr_q <= '0;
			acc_q <= '0;
			idx_q <= cmd.sweep_index;
		end
		if (advance && walk_q) begin
			ptr_q    <= ptr_q + CW'(1);
			close_s1 <= is_close;
			last_s1  <= is_close;
		end
		if (advance && valid_s1) begin
			time_s2  <= acc_q;
			start_s2 <= rd_start;
			prod_s2  <= PW'(rd_inc * $signed({1'b0, idx_q}));
			last_s2  <= last_s1;
			if (!close_s1) begin
				acc_q <= acc_sum[TIME_W] ? TIME_MAX : acc_sum[TIME_W-1:0];
			end
		end
		if (accept && cmd.kind == KIND_STEPPED) begin
			rem_q <= '0;
			quo_q <= diff_abs[VB-1:0];
			div_q <= step_abs[VB-1:0];
		end else if (state_q == S_DIV) begin
			rem_q <= fits ? VB'(trial - {1'b0, div_q}) : trial[VB-1:0];
			quo_q <= {quo_q[VB-2:0], fits};
		end
		if (state_q == S_IDLE && accept) begin
			out_status_q <= (cmd.kind == KIND_CONST) ? const_status
				: (cmd.kind == KIND_STEPPED) ? step_status
				: (count_q == '0) ? ST_EMPTY : ST_BAD_SWEEP;
			out_time_q  <= '0;
			out_volt_q  <= '0;
			out_total_q <= sweep_q;
			out_last_q  <= 1'b1;
		end else if (state_q == S_EMIT && advance && valid_s2) begin
			out_status_q <= vstatus;
			out_time_q   <= time_s2;
			out_volt_q   <= vsat;
			out_total_q  <= sweep_q;
			out_last_q   <= last_s2;
		end else if (state_q == S_FIN && advance) begin
			out_status_q <= ST_OK;
			out_time_q   <= '0;
			out_volt_q   <= '0;
			out_total_q  <= n_sat;
			out_last_q   <= 1'b1;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.status       = out_status_q;
	assign res.pair_time    = out_time_q;
	assign res.pair_voltage = out_volt_q;
	assign res.sweep_total  = out_total_q;
	assign res.last         = out_last_q;
endmodule

// ----- dv/stepped_voltage_protocol_sequencer_tb.sv -----
module stepped_voltage_protocol_sequencer_tb;
	import svps_pkg::*;

	localparam int VB = VOLTAGE_BITS_DEF;
	localparam int RANDOM_ITEMS = 90;
	localparam int LONG_HOLD = 300;
	localparam int TAIL_CYCLES = 40;

	typedef struct {
		logic [KIND_W-1:0]    kind;
		logic signed [VB-1:0] start_level;
		logic signed [VB-1:0] stop_level;
		logic signed [VB-1:0] step_level;
		logic [DUR_W-1:0]     duration;
		logic [IDX_W-1:0]     sweep_index;
	} command_t;

	typedef struct {
		logic [STATUS_W-1:0]  status;
		logic [TIME_W-1:0]    pair_time;
		logic signed [VB-1:0] pair_voltage;
		logic [COUNT_W-1:0]   sweep_total;
		logic                 last;
	} pair_t;

	class sequencer_scoreboard;
		longint          stage_start [MAX_STAGES_DEF];
		longint          stage_increment [MAX_STAGES_DEF];
		longint unsigned stage_length [MAX_STAGES_DEF];
		int              stage_count = 0;
		bit              stepped_present = 0;
		logic [COUNT_W-1:0] sweep_count = COUNT_W'(1);
		pair_t           expected_pairs[$];
		int              failures = 0;

		function int pending();
			return expected_pairs.size();
		endfunction

		function void push_pair(logic [STATUS_W-1:0] code, logic [TIME_W-1:0] at,
			logic signed [VB-1:0] volt, logic fin);
			pair_t p;
			p.status = code;
			p.pair_time = at;
			p.pair_voltage = volt;
			p.sweep_total = sweep_count;
			p.last = fin;
			expected_pairs = {expected_pairs, p};
		endfunction

		function void add_stage(longint v0, longint inc, longint unsigned len);
			stage_start[stage_count] = v0;
			stage_increment[stage_count] = inc;
			stage_length[stage_count] = len;
			stage_count++;
		endfunction

		function void note_command(command_t c);
			logic [STATUS_W-1:0] code;
			longint v0, v1, stp, n, v, vmax, vmin;
			longint unsigned t;
			logic [TIME_W-1:0] at;
			int src;
			v0 = longint'(c.start_level);
			v1 = longint'(c.stop_level);
			stp = longint'(c.step_level);
			vmax = (longint'(1) <<< (VB - 1)) - 1;
			vmin = -vmax - 1;
			code = ST_OK;
			if (c.kind == KIND_CONST) begin
				if (c.duration == 0)
					code = ST_BAD_DUR;
				else if (stage_count >= MAX_STAGES_DEF)
					code = ST_FULL;
				else
					add_stage(v0, longint'(0), 64'(c.duration));
				push_pair(code, '0, '0, 1'b1);
			end else if (c.kind == KIND_STEPPED) begin
				if (stepped_present)
					code = ST_SECOND;
				else if (c.duration == 0)
					code = ST_BAD_DUR;
				else if (stp == 0)
					code = ST_ZERO_STEP;
				else if ((v1 < v0 && stp > 0) || (v1 > v0 && stp < 0))
					code = ST_BAD_SIGN;
				else if (stage_count >= MAX_STAGES_DEF)
					code = ST_FULL;
				else begin
					n = ((v1 > v0) ? v1 - v0 : v0 - v1) / ((stp < 0) ? -stp : stp) + 1;
					add_stage(v0, stp, 64'(c.duration));
					stepped_present = 1;
					sweep_count = (n > longint'(COUNT_MAX)) ? COUNT_MAX : n[COUNT_W-1:0];
				end
				push_pair(code, '0, '0, 1'b1);
			end else if (c.kind == KIND_EMIT) begin
				if (stage_count == 0)
					push_pair(ST_EMPTY, '0, '0, 1'b1);
				else if (c.sweep_index >= sweep_count)
					push_pair(ST_BAD_SWEEP, '0, '0, 1'b1);
				else begin
					t = 0;
					// The closing pair repeats the last stage's voltage at the total time.
					for (int s = 0; s <= stage_count; s++) begin
						src = (s < stage_count) ? s : stage_count - 1;
						at = (t > longint'(TIME_MAX)) ? TIME_MAX : t[TIME_W-1:0];
						v = stage_start[src] + stage_increment[src] * longint'(c.sweep_index);
						code = ST_OK;
						if (v > vmax) begin
							v = vmax;
							code = ST_SATURATED;
						end else if (v < vmin) begin
							v = vmin;
							code = ST_SATURATED;
						end
						push_pair(code, at, v[VB-1:0], s == stage_count);
						if (s < stage_count)
							t += stage_length[s];
					end
				end
			end
		endfunction

		function void check_pair(pair_t got);
			pair_t exp_p;
			if (expected_pairs.size() == 0) begin
				$display("%0t: result with nothing expected, actual status %0d time %0d",
					$time, got.status, got.pair_time);
				failures++;
				return;
			end
			exp_p = expected_pairs.pop_front();
			if (got.status !== exp_p.status) begin
				$display("%0t: status expected %0d actual %0d", $time, exp_p.status,
					got.status);
				failures++;
			end
			if (got.pair_time !== exp_p.pair_time) begin
				$display("%0t: pair_time expected %0d actual %0d", $time, exp_p.pair_time,
					got.pair_time);
				failures++;
			end
			if (got.pair_voltage !== exp_p.pair_voltage) begin
				$display("%0t: pair_voltage expected %0d actual %0d", $time,
					exp_p.pair_voltage, got.pair_voltage);
				failures++;
			end
			if (got.sweep_total !== exp_p.sweep_total) begin
				$display("%0t: sweep_total expected %0d actual %0d", $time,
					exp_p.sweep_total, got.sweep_total);
				failures++;
			end
			if (got.last !== exp_p.last) begin
				$display("%0t: last expected %0d actual %0d", $time, exp_p.last, got.last);
				failures++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   steady = 0;

	svps_in_if #(.VOLTAGE_BITS(VB)) cmd_ch ();
	svps_out_if #(.VOLTAGE_BITS(VB)) res_ch ();

	sequencer_scoreboard sb = new();

	stepped_voltage_protocol_sequencer #(
		.MAX_STAGES(MAX_STAGES_DEF),
		.VOLTAGE_BITS(VB)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch)
	);

	always #1 clk = ~clk;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.kind = KIND_CONST;
		cmd_ch.start_level = '0;
		cmd_ch.stop_level = '0;
		cmd_ch.step_level = '0;
		cmd_ch.duration = '0;
		cmd_ch.sweep_index = '0;
		res_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int draw_gap();
		if (steady || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 12);
	endfunction

	function automatic command_t make_cmd(logic [KIND_W-1:0] kind, int v0, int v1, int stp,
		int dur, int idx);
		command_t c;
		c.kind = kind;
		c.start_level = VB'(v0);
		c.stop_level = VB'(v1);
		c.step_level = VB'(stp);
		c.duration = DUR_W'(dur);
		c.sweep_index = IDX_W'(idx);
		return c;
	endfunction

	function automatic command_t random_cmd();
		command_t c;
		int pick;
		c.start_level = VB'($urandom);
		c.stop_level = VB'($urandom);
		c.step_level = VB'($urandom);
		c.duration = DUR_W'($urandom);
		c.sweep_index = IDX_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 22) begin
			c.kind = KIND_CONST;
			if ($urandom_range(0, 7) == 0)
				c.duration = '0;
		end else if (pick < 28) begin
			c.kind = KIND_STEPPED;
		end else if (pick < 95) begin
			c.kind = KIND_EMIT;
			// Most emits ask for a sweep that exists so that the whole table is walked.
			if ($urandom_range(0, 4) != 0)
				c.sweep_index = IDX_W'($urandom_range(0, sb.sweep_count - 1));
		end else begin
			c.kind = KIND_UNUSED;
		end
		return c;
	endfunction

	task automatic send_cmd(command_t c);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.kind <= c.kind;
		cmd_ch.start_level <= c.start_level;
		cmd_ch.stop_level <= c.stop_level;
		cmd_ch.step_level <= c.step_level;
		cmd_ch.duration <= c.duration;
		cmd_ch.sweep_index <= c.sweep_index;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	always @(posedge clk) begin
		command_t c;
		pair_t p;
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				c.kind = cmd_ch.kind;
				c.start_level = cmd_ch.start_level;
				c.stop_level = cmd_ch.stop_level;
				c.step_level = cmd_ch.step_level;
				c.duration = cmd_ch.duration;
				c.sweep_index = cmd_ch.sweep_index;
				sb.note_command(c);
			end
			if (res_ch.valid && res_ch.ready) begin
				p.status = res_ch.status;
				p.pair_time = res_ch.pair_time;
				p.pair_voltage = res_ch.pair_voltage;
				p.sweep_total = res_ch.sweep_total;
				p.last = res_ch.last;
				sb.check_pair(p);
			end
		end
	end

	initial begin
		int taken;
		int gap;
		taken = 0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			// One long stall lets the block fill up and hold off its input.
			if (taken == 30) begin
				res_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			gap = draw_gap();
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (res_ch.valid !== 1'b1);
			taken++;
		end
	end

	initial begin
		command_t c;
		int sent;
		@(posedge arst_n);
		@(posedge clk);

		send_cmd(make_cmd(KIND_EMIT, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(KIND_CONST, 5, 0, 0, 0, 0));
		send_cmd(make_cmd(KIND_UNUSED, -1, -1, -1, 65535, 65535));
		send_cmd(make_cmd(KIND_STEPPED, 100, 200, 0, 10, 0));
		send_cmd(make_cmd(KIND_STEPPED, 0, 10, -32768, 10, 0));
		send_cmd(make_cmd(KIND_STEPPED, 200, 100, 32767, 10, 0));
		send_cmd(make_cmd(KIND_STEPPED, 100, 200, 5, 0, 0));
		send_cmd(make_cmd(KIND_CONST, 32767, 0, 0, 65535, 0));
		send_cmd(make_cmd(KIND_CONST, -32768, 0, 0, 1, 0));
		send_cmd(make_cmd(KIND_EMIT, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(KIND_EMIT, 0, 0, 0, 0, 1));
		// Full range with a step that does not divide it evenly.
		send_cmd(make_cmd(KIND_STEPPED, -32768, 32767, 7, 500, 0));
		send_cmd(make_cmd(KIND_STEPPED, 0, 0, 3, 20, 0));
		send_cmd(make_cmd(KIND_EMIT, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(KIND_EMIT, 0, 0, 0, 0, 9362));
		send_cmd(make_cmd(KIND_EMIT, 0, 0, 0, 0, 9363));
		send_cmd(make_cmd(KIND_EMIT, 0, 0, 0, 0, 65535));
		send_cmd(make_cmd(KIND_CONST, 0, 0, 0, 65535, 0));
		send_cmd(make_cmd(KIND_EMIT, 0, 0, 0, 0, 4681));

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent == 60) begin
				cmd_ch.valid <= 1'b0;
				wait_drained();
			end
			steady = (sent >= 65 && sent < 85);
			c = random_cmd();
			send_cmd(c);
			if (c.kind != KIND_UNUSED)
				sent++;
		end
		cmd_ch.valid <= 1'b0;
		steady = 0;

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			$display("%0t: %0d expected results never arrived", $time, sb.pending());
		if (sb.failures == 0 && sb.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/svps_pkg.sv
src/svps_in_if.sv
src/svps_out_if.sv
src/svps_ram.sv
src/stepped_voltage_protocol_sequencer.sv
dv/stepped_voltage_protocol_sequencer_tb.sv
